### design/positional_list_engine_assert.svh
// ----------------------------------------------------------------------------
// positional_list_engine_assert.svh
// Assertion macros shared by the positional list engine.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional list engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list engine: next-cycle check failed");

`endif

### design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Constants, codes and shared types of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = 11;
   localparam int VALUE_W  = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [ADDR_W-1:0]          src;
      logic [LEN_W-1:0]           moves;
      logic [ADDR_W-1:0]          shift;
      logic [ADDR_W-1:0]          put_addr;
      logic signed [VALUE_W-1:0]  value;
   } seq_cmd_type;

   typedef struct packed {
      logic                       busy;
      logic                       done;
      logic signed [VALUE_W-1:0]  read_value;
   } seq_status_type;

endpackage

### design/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ple_seq.sv
// ----------------------------------------------------------------------------
// ple_seq
// Store sequencer: shifts entries through the RAM, writes and reads entries.
// ----------------------------------------------------------------------------
module ple_seq import ple_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  seq_cmd_type    cmd,
   input  logic           rsp_free,
   output seq_status_type stat
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MOVE   = 6'b000010,
      S_PUT    = 6'b000100,
      S_READ   = 6'b001000,
      S_RWAIT  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   op_type                    op_ff, op_in;
   logic [ADDR_W-1:0]         src_ff, src_in;
   logic [LEN_W-1:0]          moves_ff, moves_in;
   logic [ADDR_W-1:0]         shift_ff, shift_in;
   logic [ADDR_W-1:0]         put_ff, put_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      pend_ff, pend_in;
   logic [ADDR_W-1:0]         dst_ff, dst_in;
   logic signed [VALUE_W-1:0] result_ff, result_in;

   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic [VALUE_W-1:0]        rd_data;
   logic                      done;

   ple_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      src_in    = src_ff;
      moves_in  = moves_ff;
      shift_in  = shift_ff;
      put_in    = put_ff;
      value_in  = value_ff;
      pend_in   = 1'b0;
      dst_in    = dst_ff;
      result_in = result_ff;
      rd_en     = 1'b0;
      rd_addr   = src_ff;
      wr_en     = 1'b0;
      wr_addr   = dst_ff;
      wr_data   = rd_data;
      done      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = cmd.op;
               src_in    = cmd.src;
               moves_in  = cmd.moves;
               shift_in  = cmd.shift;
               put_in    = cmd.put_addr;
               value_in  = cmd.value;
               result_in = '0;
               unique case (cmd.op)
                  OP_NONE: state_in = S_FINISH;
                  OP_READ: state_in = S_READ;
                  default: state_in = S_MOVE;
               endcase
            end
         end
         S_MOVE: begin
            // The entry read in the previous cycle is written to its new place,
            // while the next source entry is read.
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (moves_ff != '0) begin
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               moves_in = moves_ff - 1'b1;
               if (op_ff == OP_INSERT) begin
                  dst_in = src_ff + 1'b1;
                  src_in = src_ff - 1'b1;
               end else begin
                  dst_in = src_ff - shift_ff;
                  src_in = src_ff + 1'b1;
               end
            end else if (!pend_ff) begin
               state_in = (op_ff == OP_INSERT) ? S_PUT : S_FINISH;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = put_ff;
            wr_data  = value_ff;
            state_in = S_FINISH;
         end
         S_READ: begin
            rd_en    = 1'b1;
            rd_addr  = put_ff;
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            result_in = rd_data;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      op_ff     <= op_in;
      src_ff    <= src_in;
      moves_ff  <= moves_in;
      shift_ff  <= shift_in;
      put_ff    <= put_in;
      value_ff  <= value_in;
      dst_ff    <= dst_in;
      result_ff <= result_in;
   end

   assign stat.busy       = (state_ff != S_IDLE);
   assign stat.done       = done;
   assign stat.read_value = result_ff;

endmodule

### design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with insert, remove-run and read.
// ----------------------------------------------------------------------------
// Each item is checked against the list length when it is accepted, and the
// result carries the status and the length after the operation. The entries
// live in one RAM with one write and one read port and a registered read, and
// shifting moves one entry per cycle through it. An insert at position p moves
// the entries from p to the end up by one and then writes the value, a remove
// of c entries at p moves the entries behind the run down by c, and a read or
// a rejected item moves none. A finished result waits in the output register
// while the next item is already taken; no clearing pass follows reset.
`include "positional_list_engine_assert.svh"

module positional_list_engine import ple_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [FUNC_W-1:0]          req_func,
   input  logic [LEN_W-1:0]           req_position,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [LEN_W-1:0]           req_count,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_read_value,
   output logic [LEN_W-1:0]           rsp_list_length
);

   logic                      accept;
   logic                      rsp_free;
   seq_cmd_type               cmd;
   seq_status_type            seq_stat;

   logic [LEN_W-1:0]          len_ff, len_in;
   logic [STATUS_W-1:0]       stat_ff, stat_in;
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic signed [VALUE_W-1:0] rsp_read_value_ff;
   logic [LEN_W-1:0]          rsp_list_length_ff;

   logic [LEN_W:0]            n_ext;
   logic [LEN_W:0]            pos_ext;
   logic [LEN_W:0]            end_ext;

   assign req_stall = seq_stat.busy;
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign n_ext   = {1'b0, len_ff};
   assign pos_ext = {1'b0, req_position};
   // Last position of a run to be removed.
   assign end_ext = pos_ext - 1'b1 + {1'b0, req_count};

   always_comb begin
      stat_in      = ST_RANGE;
      len_in       = len_ff;
      cmd.op       = OP_NONE;
      cmd.src      = '0;
      cmd.moves    = '0;
      cmd.shift    = req_count[ADDR_W-1:0];
      cmd.put_addr = ADDR_W'(req_position - 1'b1);
      cmd.value    = req_value;
      unique case (req_func)
         FUNC_INSERT: begin
            if (req_position == '0 || pos_ext > n_ext + 1'b1) begin
               stat_in = ST_RANGE;
            end else if (len_ff == LEN_W'(CAPACITY)) begin
               stat_in = ST_FULL;
            end else begin
               stat_in   = ST_OK;
               len_in    = len_ff + 1'b1;
               cmd.op    = OP_INSERT;
               cmd.src   = ADDR_W'(len_ff - 1'b1);
               cmd.moves = len_ff - req_position + 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (req_position == '0 || req_count == '0 || end_ext > n_ext) begin
               stat_in = ST_RANGE;
            end else begin
               stat_in   = ST_OK;
               len_in    = len_ff - req_count;
               cmd.op    = OP_REMOVE;
               cmd.src   = end_ext[ADDR_W-1:0];
               cmd.moves = LEN_W'(n_ext - end_ext);
            end
         end
         FUNC_READ: begin
            if (req_position == '0 || pos_ext > n_ext) begin
               stat_in = ST_RANGE;
            end else begin
               stat_in = ST_OK;
               cmd.op  = OP_READ;
            end
         end
         default: stat_in = ST_RANGE;
      endcase
   end

   ple_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .cmd      (cmd),
      .rsp_free (rsp_free),
      .stat     (seq_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            len_ff <= len_in;
         end
         if (seq_stat.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         stat_ff <= stat_in;
      end
      if (seq_stat.done) begin
         rsp_status_ff      <= stat_ff;
         rsp_read_value_ff  <= seq_stat.read_value;
         rsp_list_length_ff <= len_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_list_length = rsp_list_length_ff;

   `PLE_ASSERT_IMP(a_len_within_capacity, clock, reset, 1'b1, len_ff <= LEN_W'(CAPACITY))
   `PLE_ASSERT_NEXT(a_accept_makes_busy, clock, reset, accept, seq_stat.busy)
   `PLE_ASSERT_IMP(a_done_into_free_slot, clock, reset, seq_stat.done, rsp_free)
   `PLE_ASSERT_IMP(a_rejected_reads_zero, clock, reset,
                   rsp_valid_ff && rsp_status_ff != ST_OK, rsp_read_value_ff == '0)

endmodule
